// ===== sv/egcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared payload types for the extended gcd and modular inverse block.
// ----------------------------------------------------------------------------
package egcd_pkg;

    // input transfer payload
    typedef struct packed {
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } in_item_t;

    // result transfer payload
    typedef struct packed {
        logic [31:0] gcd_value;
        logic [32:0] coef_a;
        logic [32:0] coef_b;
        logic [31:0] inverse_value;
        logic        invertible;
        logic        status;
    } out_item_t;

endpackage

// ===== sv/egcd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_front
// Accepts operand pairs, detects zero operands and orders them larger first.
// ----------------------------------------------------------------------------
module egcd_front #(
    parameter int WIDTH = 32
) (
    input  logic                in_valid,
    output logic                in_ready,
    input  egcd_pkg::in_item_t  in_data,
    output logic                job_valid,
    input  logic                job_ready,
    output logic [3*WIDTH+1:0]  job_data
);

    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
    logic             zero;
    logic             swapped;
    logic [WIDTH-1:0] big;
    logic [WIDTH-1:0] small_op;

    // keep the low bits of each operand
    assign a = WIDTH'({32'd0, in_data.operand_a});
    assign b = WIDTH'({32'd0, in_data.operand_b});

    // classify and order
    assign zero     = (a == '0) || (b == '0);
    assign swapped  = a < b;
    assign big      = swapped ? b : a;
    assign small_op = swapped ? a : b;

    assign job_data  = {zero, swapped, big, small_op, b};
    assign job_valid = in_valid;
    assign in_ready  = job_ready;

endmodule

// ===== sv/egcd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_queue
// Two-entry register queue between the front and back parts.
// ----------------------------------------------------------------------------
module egcd_queue #(
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  logic [DW-1:0] wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem_reg [2];
    logic          wptr_reg;
    logic          wptr_next;
    logic          rptr_reg;
    logic          rptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          push;
    logic          pop;

    assign wr_ready = count_reg != 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign rd_data  = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointer and fill update
    always_comb
    begin
        wptr_next  = push ? ~wptr_reg : wptr_reg;
        rptr_next  = pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/egcd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_back
// Euclid loop with a bit-serial divider that also forms quotient products,
// then the inverse reduction and the output register.
// ----------------------------------------------------------------------------
module egcd_back #(
    parameter int WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  logic [3*WIDTH+1:0]    job_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output egcd_pkg::out_item_t   out_data
);

    localparam int CW   = WIDTH + 1;
    localparam int CNTW = $clog2(WIDTH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;

    logic [2:0]        state_reg, state_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;
    logic [WIDTH-1:0]  big_reg, big_next;
    logic [WIDTH-1:0]  sml_reg, sml_next;
    logic [WIDTH-1:0]  num_reg, num_next;
    logic [WIDTH-1:0]  rem_reg, rem_next;
    logic [WIDTH-1:0]  mod_reg, mod_next;
    logic              zero_reg, zero_next;
    logic              swp_reg, swp_next;
    logic [CW-1:0]     p0_reg, p0_next, p1_reg, p1_next;
    logic [CW-1:0]     q0_reg, q0_next, q1_reg, q1_next;
    logic [CW-1:0]     accp_reg, accp_next, accq_reg, accq_next;
    logic              ovalid_reg, ovalid_next;
    egcd_pkg::out_item_t res_reg, res_next;

    logic [WIDTH:0]    r2;
    logic              ge;
    logic [WIDTH:0]    r2_sub;
    logic [CW-1:0]     ca, cb, t_inv, m_ext, t_red;
    logic [WIDTH-1:0]  inv;
    logic              j_zero, j_swp;
    logic [WIDTH-1:0]  j_big, j_sml, j_mod;
    logic              out_free;

    assign {j_zero, j_swp, j_big, j_sml, j_mod} = job_data;
    assign out_free  = !ovalid_reg || out_ready;
    assign job_ready = state_reg == ST_IDLE;
    assign out_valid = ovalid_reg;
    assign out_data  = res_reg;

    // one restoring division step
    assign r2     = {rem_reg, num_reg[WIDTH-1]};
    assign r2_sub = r2 - {1'b0, sml_reg};
    assign ge     = r2 >= {1'b0, sml_reg};

    // coefficients in original operand order and inverse reduction
    assign ca    = swp_reg ? q1_reg : p1_reg;
    assign cb    = swp_reg ? p1_reg : q1_reg;
    assign m_ext = {1'b0, mod_reg};
    assign t_inv = ca[CW-1] ? ca + m_ext : ca;
    assign t_red = (t_inv >= m_ext) ? t_inv - m_ext : t_inv;
    assign inv   = (mod_reg == WIDTH'(1)) ? '0 : t_red[WIDTH-1:0];

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        big_next    = big_reg;
        sml_next    = sml_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        mod_next    = mod_reg;
        zero_next   = zero_reg;
        swp_next    = swp_reg;
        p0_next     = p0_reg;
        p1_next     = p1_reg;
        q0_next     = q0_reg;
        q1_next     = q1_reg;
        accp_next   = accp_reg;
        accq_next   = accq_reg;
        ovalid_next = ovalid_reg && !out_ready;
        res_next    = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // load a job and start the first division, or go to finish for a zero operand
                if (job_valid)
                begin
                    zero_next  = j_zero;
                    swp_next   = j_swp;
                    big_next   = j_big;
                    sml_next   = j_sml;
                    mod_next   = j_mod;
                    num_next   = j_big;
                    rem_next   = '0;
                    accp_next  = '0;
                    accq_next  = '0;
                    p0_next    = CW'(1);
                    p1_next    = '0;
                    q0_next    = '0;
                    q1_next    = CW'(1);
                    cnt_next   = CNTW'(WIDTH);
                    state_next = j_zero ? ST_FIN : ST_DIV;
                end
            end
            ST_DIV:
            begin
                // quotient bit plus running products quo*p1 and quo*q1
                rem_next  = ge ? r2_sub[WIDTH-1:0] : r2[WIDTH-1:0];
                num_next  = {num_reg[WIDTH-2:0], ge};
                accp_next = (accp_reg << 1) + (ge ? p1_reg : '0);
                accq_next = (accq_reg << 1) + (ge ? q1_reg : '0);
                cnt_next  = cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                // zero remainder ends the loop, else update and divide again
                if (rem_reg == '0)
                begin
                    big_next   = sml_reg;
                    state_next = ST_FIN;
                end
                else
                begin
                    p1_next    = p0_reg - accp_reg;
                    p0_next    = p1_reg;
                    q1_next    = q0_reg - accq_reg;
                    q0_next    = q1_reg;
                    big_next   = sml_reg;
                    sml_next   = rem_reg;
                    num_next   = sml_reg;
                    rem_next   = '0;
                    accp_next  = '0;
                    accq_next  = '0;
                    cnt_next   = CNTW'(WIDTH);
                    state_next = ST_DIV;
                end
            end
            ST_FIN:
            begin
                // hand the result to the output register once it is free
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                    if (zero_reg)
                    begin
                        res_next        = '0;
                        res_next.status = 1'b1;
                    end
                    else
                    begin
                        res_next.gcd_value  = 32'({32'd0, big_reg});
                        res_next.coef_a     = 33'({33'd0, ca});
                        res_next.coef_b     = 33'({33'd0, cb});
                        res_next.invertible = big_reg == WIDTH'(1);
                        res_next.inverse_value =
                            (big_reg == WIDTH'(1)) ? 32'({32'd0, inv}) : 32'd0;
                        res_next.status     = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        big_reg  <= big_next;
        sml_reg  <= sml_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        mod_reg  <= mod_next;
        zero_reg <= zero_next;
        swp_reg  <= swp_next;
        p0_reg   <= p0_next;
        p1_reg   <= p1_next;
        q0_reg   <= q0_next;
        q1_reg   <= q1_next;
        accp_reg <= accp_next;
        accq_reg <= accq_next;
        res_reg  <= res_next;
    end

`ifndef SYNTH
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg != '0)
        else $error("division step with empty counter");
    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && res_reg.status |-> !res_reg.invertible && res_reg.gcd_value == '0)
        else $error("rejected item carries data");
    a_inv_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && res_reg.invertible |-> res_reg.gcd_value == 32'd1)
        else $error("invertible without unit gcd");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !out_ready |=> ovalid_reg && $stable(res_reg))
        else $error("held result changed");
`endif

endmodule

// ===== sv/extended_gcd_mod_inverse.sv =====
`timescale 1ns / 1ps
// Each Euclid step runs the bit-serial divider and then one coefficient update;
// there are up to about 46 steps at WIDTH 32.
// The back part takes a new item only once the last one is finished; the queue holds two.
// Zero-operand items skip the Euclid loop.
// Reset: rst_n asynchronous, clears queue, control state and output valid.
// ----------------------------------------------------------------------------
// extended_gcd_mod_inverse
// Extended Euclid gcd with Bezout coefficients and modular inverse.
// ----------------------------------------------------------------------------
module extended_gcd_mod_inverse #(
    parameter int WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  egcd_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output egcd_pkg::out_item_t out_data
);

    localparam int JW = 3 * WIDTH + 2;

    logic          f_valid, f_ready;
    logic [JW-1:0] f_data;
    logic          b_valid, b_ready;
    logic [JW-1:0] b_data;

    // classify and order operands
    egcd_front #(.WIDTH(WIDTH)) u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job_data  (f_data)
    );

    // decoupling queue
    egcd_queue #(.DW(JW)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_data)
    );

    // euclid engine and output register
    egcd_back #(.WIDTH(WIDTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (b_valid),
        .job_ready (b_ready),
        .job_data  (b_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
